@@ rtl/lcrq_pkg.sv @@
// Shared types and constants for the line coverage range query block.
`default_nettype none
package lcrq_pkg;

    localparam int LINES         = 256;
    localparam int IDX_BITS      = $clog2(LINES);
    localparam int LINE_BITS     = IDX_BITS + 1;
    localparam int COUNT_BITS    = 16;
    localparam int WORD_BITS     = 64;
    localparam int WORD_IDX_BITS = $clog2(WORD_BITS);
    localparam int WORDS         = LINES / WORD_BITS;
    localparam int WSEL_BITS     = (WORDS > 1) ? $clog2(WORDS) : 1;

    localparam int S_TDATA_BITS  = ((4 * LINE_BITS + 7) / 8) * 8;
    localparam int S_TUSER_BITS  = 2;
    localparam int M_TDATA_BITS  = 8;

    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam logic [0:0] REG_BOARD_SIZE = 1'b0;

    typedef enum logic [S_TUSER_BITS-1:0] {
        MODE_PLACE  = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_QUERY  = 2'd2
    } lcrq_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_WRITE,
        ST_SCAN,
        ST_DONE
    } lcrq_state_t;

    typedef struct packed {
        logic                 rd_en;
        logic                 wr_en;
        logic                 sub;
        logic                 scan_clr;
        logic                 scan_en;
        logic [WSEL_BITS-1:0] word;
    } lcrq_axis_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/line_coverage_range_query.sv @@
// Top level: stream control, configuration register, and result register.
`default_nettype none
// Rook coverage tracker for a square board of up to 256 lines per axis. Place
// and remove transactions (tuser mode 0/1) update the per-row and per-column
// piece counts by accept, count RAM read and write back, in that order.
// A query transaction (mode 2) scans each axis's occupancy bitmap in four
// 64-bit words, both axes in parallel; a finished result sits in the output
// register while the next transaction is accepted. Lines outside 1..board_size
// count as occupied; mode 3 is dropped without a result. Counts saturate and
// never go negative.
module line_coverage_range_query (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // row[8:0], col[17:9], row_end[26:18], col_end[35:27], zero fill
    input  wire logic [lcrq_pkg::S_TDATA_BITS-1:0]   s_tdata,
    // mode[1:0]
    input  wire logic [lcrq_pkg::S_TUSER_BITS-1:0]   s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // covered[0], zero fill
    output logic      [lcrq_pkg::M_TDATA_BITS-1:0]   m_tdata,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [lcrq_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  wire logic [lcrq_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic      [lcrq_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                     pready
);
    import lcrq_pkg::*;

    lcrq_state_t          state_reg, state_next;
    logic [WSEL_BITS-1:0] word_reg, word_next;
    logic [LINE_BITS-1:0] board_size_reg;
    logic [LINE_BITS-1:0] limit;
    logic                 sub_reg;
    logic [LINE_BITS-1:0] row_reg, col_reg, row_end_reg, col_end_reg;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic                 covered_reg;
    logic                 load_out;
    logic                 accept;
    logic                 row_full, col_full;
    lcrq_axis_ctrl_t      actrl;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BOARD_SIZE)
        ? APB_DATA_BITS'(board_size_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            board_size_reg <= LINE_BITS'(LINES);
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_BOARD_SIZE) begin
            board_size_reg <= pwdata[LINE_BITS-1:0];
        end
    end

    assign limit = (board_size_reg > LINE_BITS'(LINES))
        ? LINE_BITS'(LINES) : board_size_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next     = state_reg;
        word_next      = word_reg;
        load_out       = 1'b0;
        actrl          = '0;
        actrl.sub      = sub_reg;
        actrl.word     = word_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    word_next = '0;
                    case (s_tuser)
                        MODE_PLACE, MODE_REMOVE: state_next = ST_READ;
                        MODE_QUERY: begin
                            actrl.scan_clr = 1'b1;
                            state_next     = ST_SCAN;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ: begin
                actrl.rd_en = 1'b1;
                state_next  = ST_WRITE;
            end
            ST_WRITE: begin
                actrl.wr_en = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_SCAN: begin
                actrl.scan_en = 1'b1;
                word_next     = word_reg + WSEL_BITS'(1);
                if (word_reg == WSEL_BITS'(WORDS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            word_reg  <= '0;
        end else begin
            state_reg <= state_next;
            word_reg  <= word_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            sub_reg     <= (s_tuser == MODE_REMOVE);
            row_reg     <= s_tdata[LINE_BITS-1:0];
            col_reg     <= s_tdata[2*LINE_BITS-1:LINE_BITS];
            row_end_reg <= s_tdata[3*LINE_BITS-1:2*LINE_BITS];
            col_end_reg <= s_tdata[4*LINE_BITS-1:3*LINE_BITS];
        end
    end

    lcrq_axis u_row_axis (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (actrl),
        .line     (row_reg),
        .first    (row_reg),
        .last     (row_end_reg),
        .limit    (limit),
        .span_full(row_full)
    );

    lcrq_axis u_col_axis (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (actrl),
        .line     (col_reg),
        .first    (col_reg),
        .last     (col_end_reg),
        .limit    (limit),
        .span_full(col_full)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            covered_reg <= row_full || col_full;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_BITS'(covered_reg);

`ifndef SYNTHESIS
    a_query_scans: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_tuser == MODE_QUERY |=> state_reg == ST_SCAN && word_reg == '0)
        else $error("query did not start its scan");

    a_scan_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN && word_reg == WSEL_BITS'(WORDS - 1) |=> state_reg == ST_DONE)
        else $error("scan did not finish after the last word");

    a_update_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WRITE && !m_tvalid_reg |=> !m_tvalid_reg)
        else $error("place or remove produced a result");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result appeared without a finished query");
`endif

endmodule
`default_nettype wire

@@ rtl/lcrq_ram.sv @@
// Generic single-port synchronous RAM with registered read data.
`default_nettype none
module lcrq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/lcrq_axis.sv @@
// One board axis: piece counts in RAM, occupancy bitmap, and word-wise span scan.
`default_nettype none
module lcrq_axis (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire lcrq_pkg::lcrq_axis_ctrl_t ctrl,
    input  wire logic [lcrq_pkg::LINE_BITS-1:0] line,
    input  wire logic [lcrq_pkg::LINE_BITS-1:0] first,
    input  wire logic [lcrq_pkg::LINE_BITS-1:0] last,
    input  wire logic [lcrq_pkg::LINE_BITS-1:0] limit,
    output logic                         span_full
);
    import lcrq_pkg::*;

    logic [LINES-1:0]      taken_reg;
    logic [LINES-1:0]      taken_next;
    logic                  empty_reg;
    logic                  empty_next;
    logic                  line_ok;
    logic [IDX_BITS-1:0]   idx;
    logic [COUNT_BITS-1:0] ram_q;
    logic [COUNT_BITS-1:0] cur;
    logic [COUNT_BITS-1:0] cnt_new;
    logic [LINE_BITS-1:0]  lo;
    logic [LINE_BITS-1:0]  hi;
    logic [WORD_BITS-1:0]  taken_word;
    logic [WORD_BITS-1:0]  hole;

    assign line_ok = (line != '0) && (line <= LINE_BITS'(LINES));
    assign idx     = IDX_BITS'(line - LINE_BITS'(1));

    lcrq_ram #(
        .WIDTH(COUNT_BITS),
        .DEPTH(LINES)
    ) u_count_ram (
        .aclk (aclk),
        .en   ((ctrl.rd_en || ctrl.wr_en) && line_ok),
        .we   (ctrl.wr_en),
        .addr (idx),
        .wdata(cnt_new),
        .rdata(ram_q)
    );

    // a line whose occupied bit is clear holds count zero, whatever the RAM says
    always_comb begin
        cur        = taken_reg[idx] ? ram_q : '0;
        taken_next = taken_reg;
        if (ctrl.sub) begin
            cnt_new = (cur != '0) ? cur - COUNT_BITS'(1) : '0;
        end else begin
            cnt_new = (cur != {COUNT_BITS{1'b1}}) ? cur + COUNT_BITS'(1) : cur;
        end
        if (ctrl.wr_en && line_ok) begin
            taken_next[idx] = (cnt_new != '0);
        end
    end

    assign lo = (first == '0) ? '0 : first - LINE_BITS'(1);
    assign hi = (last < limit) ? last : limit;
    assign taken_word = taken_reg[ctrl.word * WORD_BITS +: WORD_BITS];

    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            hole[b] = !taken_word[b]
                && (LINE_BITS'({ctrl.word, WORD_IDX_BITS'(b)}) >= lo)
                && (LINE_BITS'({ctrl.word, WORD_IDX_BITS'(b)}) < hi);
        end
        empty_next = empty_reg;
        if (ctrl.scan_clr) begin
            empty_next = 1'b0;
        end else if (ctrl.scan_en) begin
            empty_next = empty_reg || (hole != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            taken_reg <= '0;
            empty_reg <= 1'b0;
        end else begin
            taken_reg <= taken_next;
            empty_reg <= empty_next;
        end
    end

    assign span_full = !empty_reg;

endmodule
`default_nettype wire

@@ tb/sv/line_coverage_range_query_tb.sv @@
// Self-checking testbench for the rook line coverage range query block.
`timescale 1ns / 100ps
module line_coverage_range_query_tb;
    import lcrq_pkg::*;

    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int         NUM_PHASES = 8;
    localparam int         PHASE_MOVES = 228;
    localparam int         DRAIN_CYCLES = 16;

    typedef struct packed {
        logic [1:0]           mode;
        logic [LINE_BITS-1:0] row;
        logic [LINE_BITS-1:0] col;
        logic [LINE_BITS-1:0] row_end;
        logic [LINE_BITS-1:0] col_end;
    } move_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [S_TDATA_BITS-1:0]  s_tdata = '0;
    logic [S_TUSER_BITS-1:0]  s_tuser = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0]  m_tdata;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr = '0;
    logic [APB_DATA_BITS-1:0] pwdata = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    move_t                    move_q[$];
    bit                       covered_q[$];
    int                       moves_queued = 0;
    int                       moves_taken = 0;
    int                       fail_count = 0;
    int                       send_idle_pct = 0;
    int                       stall_pct = 0;

    logic [LINE_BITS-1:0]     board_lines = 9'd256;
    logic [COUNT_BITS-1:0]    row_count [1:LINES];
    logic [COUNT_BITS-1:0]    col_count [1:LINES];

    line_coverage_range_query u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 aclk = ~aclk;

    task automatic note_failure(input string text);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%s", text);
        end
    endtask

    // one axis: place or remove a piece on a line, saturating at both ends
    function automatic void move_piece(input bit col_axis, input int line, input bit lift);
        logic [COUNT_BITS-1:0] n;
        if (line < 1 || line > LINES) begin
            return;
        end
        n = col_axis ? col_count[line] : row_count[line];
        if (lift && n != '0) begin
            n = n - 1'b1;
        end else if (!lift && n != '1) begin
            n = n + 1'b1;
        end
        if (col_axis) begin
            col_count[line] = n;
        end else begin
            row_count[line] = n;
        end
    endfunction

    // lines outside 1..board_lines always count as occupied
    function automatic bit span_full(input bit col_axis, input int first, input int last);
        int lim;
        lim = (board_lines > LINES) ? LINES : int'(board_lines);
        if (first < 1) begin
            first = 1;
        end
        if (last > lim) begin
            last = lim;
        end
        for (int l = first; l <= last; l++) begin
            if ((col_axis ? col_count[l] : row_count[l]) == '0) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic void add_move(input logic [1:0] mode, input int row, input int col,
                                     input int row_end, input int col_end);
        move_t m;
        m.mode    = mode;
        m.row     = LINE_BITS'(row);
        m.col     = LINE_BITS'(col);
        m.row_end = LINE_BITS'(row_end);
        m.col_end = LINE_BITS'(col_end);
        move_q.insert(move_q.size(), m);
        moves_queued++;
    endfunction

    function automatic logic [LINE_BITS-1:0] pick_line(input int hi);
        if ($urandom_range(6) == 0) begin
            return LINE_BITS'($urandom_range(511));
        end
        return LINE_BITS'($urandom_range(hi, 1));
    endfunction

    function automatic logic [LINE_BITS-1:0] pick_end(input int first, input int hi);
        int r;
        int len;
        r = $urandom_range(9);
        len = ($urandom_range(3) == 0) ? $urandom_range(hi) : $urandom_range(4);
        if (r == 0) begin
            return LINE_BITS'($urandom_range(511));
        end
        if (r == 1) begin
            return LINE_BITS'(first - $urandom_range(3, 1));
        end
        return (first + len > 511) ? 9'd511 : LINE_BITS'(first + len);
    endfunction

    function automatic void add_random_move(input int hi);
        move_t m;
        int pick;
        pick = $urandom_range(99);
        m.mode = (pick < 45) ? MODE_PLACE : (pick < 68) ? MODE_REMOVE :
                 (pick < 96) ? MODE_QUERY : MODE_SPARE;
        m.row = pick_line(hi);
        m.col = pick_line(hi);
        if (m.mode == MODE_QUERY) begin
            m.row_end = pick_end(m.row, hi);
            m.col_end = pick_end(m.col, hi);
        end else begin
            m.row_end = LINE_BITS'($urandom_range(511));
            m.col_end = LINE_BITS'($urandom_range(511));
        end
        move_q.insert(move_q.size(), m);
        moves_queued++;
    endfunction

    task automatic wait_results();
        while (moves_taken != moves_queued || covered_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic settle();
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_board_size(input int value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_BOARD_SIZE, 2'b00};
        pwdata  <= APB_DATA_BITS'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board_lines = LINE_BITS'(value);
    endtask

    // driver
    always @(posedge aclk) begin
        move_t m;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (move_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                m = move_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= m.mode;
                s_tdata  <= S_TDATA_BITS'({m.col_end, m.row_end, m.col, m.row});
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // monitor: check results, then predict from the accepted transaction
    always @(posedge aclk) begin
        move_t m;
        bit want;
        if (!aresetn) begin
            for (int l = 1; l <= LINES; l++) begin
                row_count[l] = '0;
                col_count[l] = '0;
            end
        end else begin
            if (m_tvalid && m_tready) begin
                if (covered_q.size() == 0) begin
                    note_failure($sformatf("unexpected result: covered=%0b", m_tdata[0]));
                end else begin
                    want = covered_q.pop_front();
                    if (m_tdata[0] !== want) begin
                        note_failure($sformatf("covered mismatch: expected %0b, got %0b",
                                               want, m_tdata[0]));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                m.mode    = s_tuser;
                m.row     = s_tdata[LINE_BITS-1:0];
                m.col     = s_tdata[2*LINE_BITS-1:LINE_BITS];
                m.row_end = s_tdata[3*LINE_BITS-1:2*LINE_BITS];
                m.col_end = s_tdata[4*LINE_BITS-1:3*LINE_BITS];
                moves_taken++;
                if (m.mode == MODE_PLACE || m.mode == MODE_REMOVE) begin
                    move_piece(1'b0, m.row, m.mode == MODE_REMOVE);
                    move_piece(1'b1, m.col, m.mode == MODE_REMOVE);
                end else if (m.mode == MODE_QUERY) begin
                    covered_q.insert(covered_q.size(),
                                     span_full(1'b0, m.row, m.row_end) ||
                                     span_full(1'b1, m.col, m.col_end));
                end
            end
        end
    end

    initial begin
        #100_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int sizes [NUM_PHASES] = '{1, 0, 511, 37, 256, 130, 64, 2};
        int hi;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed moves at the reset board size
        add_move(MODE_QUERY, 1, 1, 256, 256);
        add_move(MODE_QUERY, 5, 9, 4, 8);
        add_move(MODE_QUERY, 0, 300, 0, 511);
        add_move(MODE_PLACE, 1, 1, 511, 511);
        add_move(MODE_PLACE, 256, 256, 0, 0);
        add_move(MODE_PLACE, 511, 0, 0, 0);
        add_move(MODE_PLACE, 0, 256, 0, 0);
        add_move(MODE_QUERY, 1, 2, 1, 2);
        add_move(MODE_QUERY, 2, 2, 2, 255);
        add_move(MODE_QUERY, 2, 256, 255, 256);
        add_move(MODE_QUERY, 256, 3, 511, 3);
        add_move(MODE_REMOVE, 1, 1, 0, 0);
        add_move(MODE_REMOVE, 1, 1, 0, 0);
        add_move(MODE_QUERY, 1, 1, 1, 1);
        add_move(MODE_REMOVE, 511, 511, 511, 511);
        add_move(MODE_REMOVE, 0, 0, 0, 0);
        add_move(MODE_SPARE, 511, 511, 511, 511);
        add_move(MODE_SPARE, 0, 0, 0, 0);
        add_move(MODE_QUERY, 511, 511, 511, 511);
        add_move(MODE_QUERY, 256, 256, 256, 256);
        add_move(MODE_QUERY, 1, 1, 511, 0);
        settle();

        // stack pieces on row 7 and column 9, then drain past empty
        @(negedge aclk);
        for (int i = 0; i < 3; i++) begin
            add_move(MODE_PLACE, 7, 9, 0, 0);
        end
        add_move(MODE_QUERY, 7, 2, 7, 2);
        add_move(MODE_REMOVE, 7, 9, 0, 0);
        add_move(MODE_REMOVE, 7, 9, 0, 0);
        add_move(MODE_QUERY, 7, 2, 7, 2);
        add_move(MODE_REMOVE, 7, 9, 0, 0);
        add_move(MODE_REMOVE, 7, 9, 0, 0);
        add_move(MODE_QUERY, 7, 2, 7, 2);
        add_move(MODE_QUERY, 2, 9, 2, 9);
        settle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_board_size(sizes[p]);
            @(negedge aclk);
            send_idle_pct = (p % 4 == 1) ? 82 : (p % 4 == 3) ? 24 : 0;
            stall_pct     = (p % 4 == 2) ? 82 : (p % 4 == 3) ? 24 : 0;
            hi = (sizes[p] < 1) ? 1 : (sizes[p] > LINES) ? LINES : sizes[p];
            for (int i = 0; i < PHASE_MOVES / 2; i++) begin
                add_random_move(hi);
            end
            // sender holds off until every pending result is back
            wait_results();
            @(negedge aclk);
            for (int i = 0; i < PHASE_MOVES / 2; i++) begin
                add_random_move(hi);
            end
            settle();
        end

        if (covered_q.size() != 0) begin
            note_failure($sformatf("%0d results never arrived", covered_q.size()));
        end
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
